// File: rtl/core/kmsm_pkg.sv
// ----------------------------------------------------------------------------
// kmsm_pkg
// Shared widths, opcodes and the per-item control record of the k-mer
// similarity metric pipeline.
// ----------------------------------------------------------------------------
package kmsm_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int FRAC_BITS   = 24;
	localparam int MANT_BITS   = 30;

	localparam int VW   = 32;
	localparam int DW   = COUNT_WIDTH + 1;
	localparam int PW   = 2 * COUNT_WIDTH;
	localparam int RW   = COUNT_WIDTH;
	localparam int NW   = COUNT_WIDTH + FRAC_BITS + RW - 1;
	localparam int QW   = VW;
	localparam int RMW  = DW + QW;
	localparam int MBW  = $clog2(PW);
	localparam int EW   = $clog2(COUNT_WIDTH);
	localparam int LW   = EW + MANT_BITS;
	localparam int KW   = 6;
	localparam int KSTEP = 5;
	localparam int KST  = (LW + KSTEP - 1) / KSTEP;
	localparam int KPAD = KST * KSTEP;
	localparam int WW   = KPAD + FRAC_BITS;

	localparam logic [31:0]   LN2_Q32    = 32'hB17217F7;
	localparam logic [KW-1:0] KMER_RESET = 6'd18;

	localparam logic [2:0] OP_JACCARD = 3'd0;
	localparam logic [2:0] OP_MIN     = 3'd1;
	localparam logic [2:0] OP_MAX     = 3'd2;
	localparam logic [2:0] OP_COSINE  = 3'd3;
	localparam logic [2:0] OP_MASH    = 3'd4;

	typedef struct packed {
		logic [2:0]             op;
		logic                   bad;
		logic                   n_zero;
		logic                   flat;
		logic [EW-1:0]          e;
		logic [EW-1:0]          s;
		logic [COUNT_WIDTH-1:0] n;
		logic [DW-1:0]          sum;
		logic [DW-1:0]          dq;
		logic [DW-1:0]          dm;
	} item_t;

endpackage

// File: rtl/core/kmer_similarity_metric_unit.sv
// ----------------------------------------------------------------------------
// kmer_similarity_metric_unit
// Jaccard, min, max, cosine and mash metrics of one common k-mer count cell,
// unsigned Q8.24 results, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------
//  input     start / busy              opcode, common_count, query_count,
//                                      reference_count
//  result    done (one-cycle strobe)   metric_value, status
//  config    cfg_valid / cfg_ready     cfg_data (k-mer length)
//
//  one word enters every cycle; busy stays low
//  the pipe has 5 front stages, 32 square root stages, 2 divider setup
//  stages, 32 divider stages, 30 log squaring stages, 2 ln stages,
//  7 divide-by-k stages and the output register
//  reset clears all valid bits and loads the k-mer length with 18
//  the result side takes every word, so nothing in the pipe ever waits
// ----------------------------------------------------------------------------
module kmer_similarity_metric_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [2:0]                       opcode,
	input  logic [kmsm_pkg::COUNT_WIDTH-1:0] common_count,
	input  logic [kmsm_pkg::COUNT_WIDTH-1:0] query_count,
	input  logic [kmsm_pkg::COUNT_WIDTH-1:0] reference_count,
	output logic                             done,
	output logic [kmsm_pkg::VW-1:0]          metric_value,
	output logic                             status,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kmsm_pkg::KW-1:0]          cfg_data
);
	import kmsm_pkg::*;

	localparam logic [VW-1:0] ONE_Q = VW'(1) << FRAC_BITS;

	function automatic logic [MBW-1:0] msb_idx(input logic [PW-1:0] x);
		logic [MBW-1:0] r;
		r = '0;
		for (int i = 0; i < PW; i++) begin
			if (x[i]) r = MBW'(i);
		end
		return r;
	endfunction

	logic [KW-1:0] klen_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) klen_q <= KMER_RESET;
		else if (cfg_valid && cfg_ready) klen_q <= cfg_data;
	end

	// stage 1: input capture
	logic                   v_s1;
	logic [2:0]             op_s1;
	logic [COUNT_WIDTH-1:0] n_s1, a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		n_s1  <= common_count;
		a_s1  <= query_count;
		b_s1  <= reference_count;
	end

	// stage 2: sums, product, classification
	logic [DW-1:0] a_x, b_x, n_x, sum_c, jden_c, den2_c, dmin_c, dmax_c;
	logic [PW-1:0] p_c;
	logic          bad_c;
	item_t         it_c;

	always_comb begin
		a_x    = {1'b0, a_s1};
		b_x    = {1'b0, b_s1};
		n_x    = {1'b0, n_s1};
		sum_c  = a_x + b_x;
		jden_c = sum_c - n_x;
		den2_c = {n_s1, 1'b0};
		dmin_c = (a_x < b_x) ? a_x : b_x;
		dmax_c = (a_x < b_x) ? b_x : a_x;
		p_c    = PW'(a_s1) * PW'(b_s1);
		case (op_s1)
			OP_JACCARD: bad_c = (sum_c <= n_x);
			OP_MIN:     bad_c = (dmin_c == '0);
			OP_MAX:     bad_c = (dmax_c == '0);
			OP_COSINE:  bad_c = (a_s1 == '0) || (b_s1 == '0);
			OP_MASH:    bad_c = (sum_c <= n_x);
			default:    bad_c = 1'b1;
		endcase
		it_c        = '0;
		it_c.op     = op_s1;
		it_c.bad    = bad_c;
		it_c.n_zero = (n_s1 == '0);
		it_c.flat   = (sum_c <= den2_c);
		it_c.n      = n_s1;
		it_c.sum    = sum_c;
		case (op_s1)
			OP_JACCARD: it_c.dq = jden_c;
			OP_MIN:     it_c.dq = dmin_c;
			default:    it_c.dq = dmax_c;
		endcase
	end

	logic          v_s2;
	item_t         it_s2;
	logic [PW-1:0] p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		it_s2 <= it_c;
		p_s2  <= p_c;
	end

	// stage 3: leading one positions
	logic           v_s3;
	item_t          it_s3;
	logic [PW-1:0]  p_s3;
	logic [MBW-1:0] msbp_s3, msbs_s3, msbd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		it_s3   <= it_s2;
		p_s3    <= p_s2;
		msbp_s3 <= msb_idx(p_s2);
		msbs_s3 <= msb_idx(PW'(it_s2.sum));
		msbd_s3 <= msb_idx(PW'({it_s2.n, 1'b0}));
	end

	// stage 4: normalizing shifts
	logic [EW-1:0]  s_c;
	logic [MBW-1:0] ld_c;
	item_t          it4_c;

	always_comb begin
		s_c      = EW'((MBW'(PW - 1) - msbp_s3) >> 1);
		ld_c     = msbs_s3 - msbd_s3;
		it4_c    = it_s3;
		it4_c.s  = s_c;
	end

	logic           v_s4;
	item_t          it_s4;
	logic [PW-1:0]  p_s4;
	logic [MBW-1:0] ld_s4;
	logic [DW-1:0]  dsh_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		it_s4  <= it4_c;
		p_s4   <= p_s3 << {s_c, 1'b0};
		ld_s4  <= ld_c;
		dsh_s4 <= DW'({it_s3.n, 1'b0}) << ld_c;
	end

	// stage 5: mash exponent and mantissa divisor
	logic  ge5_c;
	item_t it5_c;

	always_comb begin
		ge5_c    = (it_s4.sum >= dsh_s4);
		it5_c    = it_s4;
		it5_c.e  = ge5_c ? EW'(ld_s4) : EW'(ld_s4 - MBW'(1));
		it5_c.dm = ge5_c ? dsh_s4 : (dsh_s4 >> 1);
	end

	logic          v_s5;
	item_t         it_s5;
	logic [PW-1:0] p_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		it_s5 <= it5_c;
		p_s5  <= p_s4;
	end

	// square root, one root bit per stage
	logic          sq_v_s    [RW+1];
	item_t         sq_it_s   [RW+1];
	logic [PW-1:0] sq_p_s    [RW+1];
	logic [RW+1:0] sq_rem_s  [RW+1];
	logic [RW-1:0] sq_root_s [RW+1];

	assign sq_v_s[0]    = v_s5;
	assign sq_it_s[0]   = it_s5;
	assign sq_p_s[0]    = p_s5;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [RW+3:0] tmp, trial;
		logic          ge;

		always_comb begin
			tmp   = {sq_rem_s[j], sq_p_s[j][PW-1-2*j -: 2]};
			trial = {2'b00, sq_root_s[j], 2'b01};
			ge    = (tmp >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[j+1] <= 1'b0;
			else sq_v_s[j+1] <= sq_v_s[j];
		end

		always_ff @(posedge clk) begin
			sq_it_s[j+1]   <= sq_it_s[j];
			sq_p_s[j+1]    <= sq_p_s[j];
			sq_rem_s[j+1]  <= ge ? (RW+2)'(tmp - trial) : (RW+2)'(tmp);
			sq_root_s[j+1] <= {sq_root_s[j][RW-2:0], ge};
		end
	end

	// stage 6: dividend and divisor select
	logic [6:0]    gsh_c;
	logic [NW-1:0] dn_c;
	logic [DW-1:0] dd_c;

	always_comb begin
		gsh_c = 7'(FRAC_BITS) + 7'(sq_it_s[RW].s);
		case (sq_it_s[RW].op)
			OP_COSINE: begin
				dn_c = NW'(sq_it_s[RW].n) << gsh_c;
				dd_c = DW'(sq_root_s[RW]);
			end
			OP_MASH: begin
				dn_c = NW'(sq_it_s[RW].sum) << MANT_BITS;
				dd_c = sq_it_s[RW].dm;
			end
			default: begin
				dn_c = NW'(sq_it_s[RW].n) << FRAC_BITS;
				dd_c = sq_it_s[RW].dq;
			end
		endcase
	end

	logic          v_s6;
	item_t         it_s6;
	logic [NW-1:0] dn_s6;
	logic [DW-1:0] dd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= sq_v_s[RW];
	end

	always_ff @(posedge clk) begin
		it_s6 <= sq_it_s[RW];
		dn_s6 <= dn_c;
		dd_s6 <= dd_c;
	end

	// stage 7: saturation check
	logic           v_s7;
	item_t          it_s7;
	logic           sat_s7;
	logic [RMW-1:0] rem_s7;
	logic [DW-1:0]  dd_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		it_s7  <= it_s6;
		sat_s7 <= (dn_s6 >= (NW'(dd_s6) << QW));
		rem_s7 <= dn_s6[RMW-1:0];
		dd_s7  <= dd_s6;
	end

	// restoring divider, one quotient bit per stage
	logic           dv_v_s   [QW+1];
	item_t          dv_it_s  [QW+1];
	logic           dv_sat_s [QW+1];
	logic [RMW-1:0] dv_rem_s [QW+1];
	logic [DW-1:0]  dv_d_s   [QW+1];
	logic [QW-1:0]  dv_q_s   [QW+1];

	assign dv_v_s[0]   = v_s7;
	assign dv_it_s[0]  = it_s7;
	assign dv_sat_s[0] = sat_s7;
	assign dv_rem_s[0] = rem_s7;
	assign dv_d_s[0]   = dd_s7;
	assign dv_q_s[0]   = '0;

	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [RMW-1:0] dsh;
		logic           ge;

		always_comb begin
			dsh = RMW'(dv_d_s[i]) << (QW - 1 - i);
			ge  = (dv_rem_s[i] >= dsh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[i+1] <= 1'b0;
			else dv_v_s[i+1] <= dv_v_s[i];
		end

		always_ff @(posedge clk) begin
			dv_it_s[i+1]  <= dv_it_s[i];
			dv_sat_s[i+1] <= dv_sat_s[i];
			dv_d_s[i+1]   <= dv_d_s[i];
			dv_rem_s[i+1] <= ge ? (dv_rem_s[i] - dsh) : dv_rem_s[i];
			dv_q_s[i+1]   <= {dv_q_s[i][QW-2:0], ge};
		end
	end

	// log2 fraction by repeated squaring, one bit per stage
	logic                 sg_v_s    [MANT_BITS+1];
	item_t                sg_it_s   [MANT_BITS+1];
	logic [VW-1:0]        sg_qv_s   [MANT_BITS+1];
	logic [MANT_BITS:0]   sg_m_s    [MANT_BITS+1];
	logic [MANT_BITS-1:0] sg_frac_s [MANT_BITS+1];

	assign sg_v_s[0]    = dv_v_s[QW];
	assign sg_it_s[0]   = dv_it_s[QW];
	assign sg_qv_s[0]   = dv_sat_s[QW] ? '1 : dv_q_s[QW];
	assign sg_m_s[0]    = dv_q_s[QW][MANT_BITS:0];
	assign sg_frac_s[0] = '0;

	for (genvar i = 0; i < MANT_BITS; i++) begin : g_sqr
		logic [2*MANT_BITS+1:0] prod;
		logic                   hb;

		always_comb begin
			prod = (2*MANT_BITS+2)'(sg_m_s[i]) * (2*MANT_BITS+2)'(sg_m_s[i]);
			hb   = prod[2*MANT_BITS+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sg_v_s[i+1] <= 1'b0;
			else sg_v_s[i+1] <= sg_v_s[i];
		end

		always_ff @(posedge clk) begin
			sg_it_s[i+1]   <= sg_it_s[i];
			sg_qv_s[i+1]   <= sg_qv_s[i];
			sg_m_s[i+1]    <= hb ? prod[2*MANT_BITS+1:MANT_BITS+1]
			                     : prod[2*MANT_BITS:MANT_BITS];
			sg_frac_s[i+1] <= {sg_frac_s[i][MANT_BITS-2:0], hb};
		end
	end

	// stage 8: log2 to ln, partial products
	logic [LW-1:0] l_c;

	assign l_c = {sg_it_s[MANT_BITS].e, sg_frac_s[MANT_BITS]};

	logic          v_s8;
	item_t         it_s8;
	logic [VW-1:0] qv_s8;
	logic [63:0]   lo_s8;
	logic [LW-1:0] hi_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else v_s8 <= sg_v_s[MANT_BITS];
	end

	always_ff @(posedge clk) begin
		it_s8 <= sg_it_s[MANT_BITS];
		qv_s8 <= sg_qv_s[MANT_BITS];
		lo_s8 <= 64'(l_c[31:0]) * 64'(LN2_Q32);
		hi_s8 <= LW'(l_c[LW-1:32]) * LW'(LN2_Q32);
	end

	// stage 9: ln sum
	logic          v_s9;
	item_t         it_s9;
	logic [VW-1:0] qv_s9;
	logic [LW-1:0] ln_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		it_s9 <= it_s8;
		qv_s9 <= qv_s8;
		ln_s9 <= hi_s8 + LW'(lo_s8[63:32]);
	end

	// divide by k, several quotient bits per stage
	logic            kd_v_s   [KST+1];
	item_t           kd_it_s  [KST+1];
	logic [VW-1:0]   kd_qv_s  [KST+1];
	logic [KPAD-1:0] kd_n_s   [KST+1];
	logic [KPAD-1:0] kd_q_s   [KST+1];
	logic [KW-1:0]   kd_rem_s [KST+1];

	assign kd_v_s[0]   = v_s9;
	assign kd_it_s[0]  = it_s9;
	assign kd_qv_s[0]  = qv_s9;
	assign kd_n_s[0]   = KPAD'(ln_s9);
	assign kd_q_s[0]   = '0;
	assign kd_rem_s[0] = '0;

	for (genvar i = 0; i < KST; i++) begin : g_kdiv
		logic [KW:0]     x;
		logic [KW-1:0]   r;
		logic [KPAD-1:0] q;
		logic            g;

		always_comb begin
			r = kd_rem_s[i];
			q = kd_q_s[i];
			x = '0;
			g = 1'b0;
			for (int t = 0; t < KSTEP; t++) begin
				x = {r, kd_n_s[i][KPAD-1-(i*KSTEP+t)]};
				g = (x >= {1'b0, klen_q});
				if (g) x = x - {1'b0, klen_q};
				r = x[KW-1:0];
				q = {q[KPAD-2:0], g};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) kd_v_s[i+1] <= 1'b0;
			else kd_v_s[i+1] <= kd_v_s[i];
		end

		always_ff @(posedge clk) begin
			kd_it_s[i+1]  <= kd_it_s[i];
			kd_qv_s[i+1]  <= kd_qv_s[i];
			kd_n_s[i+1]   <= kd_n_s[i];
			kd_q_s[i+1]   <= q;
			kd_rem_s[i+1] <= r;
		end
	end

	// output select
	item_t         itf;
	logic [WW-1:0] wide_c;
	logic [VW-1:0] mash_c, val_c;
	logic          bad_f;

	always_comb begin
		itf    = kd_it_s[KST];
		wide_c = (WW'(kd_q_s[KST]) << FRAC_BITS) >> MANT_BITS;
		mash_c = (wide_c > WW'({VW{1'b1}})) ? '1 : wide_c[VW-1:0];
		bad_f  = itf.bad ||
		         ((itf.op == OP_MASH) && !itf.n_zero && (klen_q == '0));
		case (itf.op)
			OP_MASH: begin
				if (itf.n_zero) val_c = ONE_Q;
				else if (itf.flat) val_c = '0;
				else val_c = mash_c;
			end
			default: val_c = kd_qv_s[KST];
		endcase
		if (bad_f) val_c = '0;
	end

	logic          done_q, status_q;
	logic [VW-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= kd_v_s[KST];
	end

	always_ff @(posedge clk) begin
		value_q  <= val_c;
		status_q <= bad_f;
	end

	assign done         = done_q;
	assign metric_value = value_q;
	assign status       = status_q;

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> metric_value == '0)
		else $error("status set with nonzero value");

	a_root_norm: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[RW] && (sq_it_s[RW].op == OP_COSINE) && !sq_it_s[RW].bad
		|-> sq_root_s[RW][RW-1])
		else $error("cosine root not normalized");

	a_mant_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[QW] && (dv_it_s[QW].op == OP_MASH) && !dv_it_s[QW].bad &&
		!dv_it_s[QW].n_zero && !dv_it_s[QW].flat
		|-> !dv_sat_s[QW] && ((dv_q_s[QW] >> MANT_BITS) == QW'(1)))
		else $error("mash mantissa out of range");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the k-mer similarity metric unit word by word against a predictor of
// the jaccard, min, max, cosine and mash arithmetic, under several k-mer
// length settings, with random gaps or back-to-back runs of input words.
// ----------------------------------------------------------------------------
module testbench;
	import kmsm_pkg::*;

	localparam logic [2:0]  OP_SPARE_A   = 3'd5;
	localparam logic [2:0]  OP_SPARE_B   = 3'd6;
	localparam logic [2:0]  OP_SPARE_C   = 3'd7;
	localparam logic        ST_OK        = 1'b0;
	localparam logic        ST_NO_DEN    = 1'b1;
	localparam logic [63:0] SAT_MAX      = 64'hFFFF_FFFF;
	localparam int          PIPE_DRAIN   = 130;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          PHASE_WORDS  = 225;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] n;
		logic [31:0] a;
		logic [31:0] b;
		bit          typed;
		logic [31:0] value;
		logic        stat;
	} cell_t;

	typedef struct {
		logic [31:0] value;
		logic        stat;
	} metric_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] opcode = '0;
	logic [31:0] common_count = '0;
	logic [31:0] query_count = '0;
	logic [31:0] reference_count = '0;
	logic done;
	logic [31:0] metric_value;
	logic status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [KW-1:0] cfg_data = '0;

	logic [KW-1:0] kmer_k = KMER_RESET;
	metric_t pending_metrics[$];
	cell_t directed_cells[$];
	int mismatches = 0;
	int checked = 0;
	int cycles = 0;
	int settings = 1;

	kmer_similarity_metric_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.common_count(common_count), .query_count(query_count),
		.reference_count(reference_count), .done(done), .metric_value(metric_value),
		.status(status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] frac_quotient(logic [63:0] n, logic [63:0] d, int g);
		logic [63:0] q;
		logic [63:0] r;
		q = n / d;
		r = n % d;
		if (q > SAT_MAX)
			return SAT_MAX;
		for (int i = 0; i < g; i++) begin
			q = q << 1;
			if (r >= d - r) begin
				r = r - (d - r);
				q[0] = 1'b1;
			end else begin
				r = r + r;
			end
			if (q > SAT_MAX)
				return SAT_MAX;
		end
		return q;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// natural log of num/den in 30 fraction bits
	function automatic logic [63:0] log_ratio(logic [63:0] num, logic [63:0] den);
		int e;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] l;
		e = 0;
		frac = 0;
		while (e < 63 && (num >> (e + 1)) >= den)
			e++;
		if (e <= MANT_BITS)
			m = frac_quotient(num, den, MANT_BITS - e);
		else
			m = (num / den) >> (e - MANT_BITS);
		for (int i = 0; i < MANT_BITS; i++) begin
			m = (m * m) >> MANT_BITS;
			frac = frac << 1;
			if (m >= (64'd1 << (MANT_BITS + 1))) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		l = (64'(e) << MANT_BITS) | frac;
		return (l >> 32) * LN2_Q32 + (((l & SAT_MAX) * LN2_Q32) >> 32);
	endfunction

	function automatic metric_t predict_metric(logic [2:0] op, logic [31:0] n32,
			logic [31:0] a32, logic [31:0] b32, logic [KW-1:0] k);
		metric_t res;
		logic [63:0] n, a, b, sum, d, p, v;
		int s;
		bit bad;
		n = n32;
		a = a32;
		b = b32;
		sum = a + b;
		v = 0;
		bad = 0;
		case (op)
			OP_JACCARD: begin
				if (sum <= n) bad = 1;
				else v = frac_quotient(n, sum - n, FRAC_BITS);
			end
			OP_MIN, OP_MAX: begin
				d = (op == OP_MIN) ? ((a < b) ? a : b) : ((a > b) ? a : b);
				if (d == 0) bad = 1;
				else v = frac_quotient(n, d, FRAC_BITS);
			end
			OP_COSINE: begin
				p = a * b;
				s = 0;
				if (p == 0) begin
					bad = 1;
				end else begin
					while (p < (64'd1 << 62)) begin
						p = p << 2;
						s++;
					end
					v = frac_quotient(n, root_floor(p), FRAC_BITS + s);
				end
			end
			OP_MASH: begin
				if (sum <= n) bad = 1;
				else if (n == 0) v = frac_quotient(1, 1, FRAC_BITS);
				else if (k == 0) bad = 1;
				else if (sum > n + n) begin
					v = (log_ratio(sum, n + n) / k) >> (MANT_BITS - FRAC_BITS);
					if (v > SAT_MAX) v = SAT_MAX;
				end
			end
			default: bad = 1;
		endcase
		res.value = bad ? 32'd0 : v[31:0];
		res.stat = bad ? ST_NO_DEN : ST_OK;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("tb: mismatch on %s at cycle %0d: got %h, want %h", what, cycles, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		metric_t want;
		if (arst_n && done) begin
			if (pending_metrics.size() == 0) begin
				report_mismatch("unexpected word", metric_value, 32'd0);
			end else begin
				want = pending_metrics.pop_front();
				checked++;
				if (metric_value !== want.value)
					report_mismatch("metric_value", metric_value, want.value);
				if (status !== want.stat)
					report_mismatch("status", {31'd0, status}, {31'd0, want.stat});
			end
		end
	end

	task automatic send_cell(cell_t c, int gap);
		metric_t want;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= c.op;
		common_count <= c.n;
		query_count <= c.a;
		reference_count <= c.b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		want = predict_metric(c.op, c.n, c.a, c.b, kmer_k);
		if (c.typed && (want.value !== c.value || want.stat !== c.stat))
			report_mismatch("typed expectation", want.value, c.value);
		if (c.typed) begin
			want.value = c.value;
			want.stat = c.stat;
		end
		pending_metrics = {pending_metrics, want};
	endtask

	task automatic drain_pipe();
		start <= 1'b0;
		while (pending_metrics.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_klen(logic [KW-1:0] k);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		kmer_k = k;
		cfg_valid <= 1'b0;
		settings++;
	endtask

	function automatic logic [31:0] draw_count();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 15);
			2: return $urandom() & 32'((64'd1 << $urandom_range(1, 32)) - 1);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'd0;
					1: return 32'd1;
					2: return 32'hFFFF_FFFE;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic cell_t draw_cell();
		cell_t c;
		logic [31:0] lo;
		int pick;
		pick = $urandom_range(0, 19);
		c.typed = 0;
		c.value = 0;
		c.stat = ST_OK;
		c.a = draw_count();
		c.b = draw_count();
		if (pick >= 18) begin
			c.op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
			c.n = draw_count();
		end else begin
			c.op = 3'(pick % 5);
			if ($urandom_range(0, 3) == 0) begin
				c.n = draw_count();
			end else begin
				lo = (c.a < c.b) ? c.a : c.b;
				c.n = $urandom_range(0, lo);
			end
		end
		return c;
	endfunction

	initial begin
		logic [KW-1:0] k_plan[$];
		bit steady;
		directed_cells = '{
			'{OP_JACCARD, 32'd0, 32'd0, 32'd0, 1, 32'd0, ST_NO_DEN},
			'{OP_JACCARD, 32'd1, 32'd1, 32'd1, 1, 32'h0100_0000, ST_OK},
			'{OP_JACCARD, '1, '1, '1, 1, 32'h0100_0000, ST_OK},
			'{OP_JACCARD, 32'd100, 32'd300, 32'd500, 0, 32'd0, ST_OK},
			'{OP_MIN, 32'd5, 32'd0, 32'd7, 1, 32'd0, ST_NO_DEN},
			'{OP_MIN, '1, 32'd1, '1, 1, 32'hFFFF_FFFF, ST_OK},
			'{OP_MIN, 32'd777, 32'd12345, 32'd999, 0, 32'd0, ST_OK},
			'{OP_MAX, 32'd0, '1, '1, 1, 32'd0, ST_OK},
			'{OP_MAX, 32'd1, 32'd2, 32'd1, 1, 32'h0080_0000, ST_OK},
			'{OP_MAX, 32'd9, 32'd0, 32'd0, 1, 32'd0, ST_NO_DEN},
			'{OP_COSINE, 32'd3, 32'd0, 32'd8, 1, 32'd0, ST_NO_DEN},
			'{OP_COSINE, 32'd4, 32'd4, 32'd4, 1, 32'h0100_0000, ST_OK},
			'{OP_COSINE, '1, '1, '1, 1, 32'h0100_0000, ST_OK},
			'{OP_COSINE, 32'd12345, 32'd678901, 32'd23456, 0, 32'd0, ST_OK},
			'{OP_MASH, 32'd0, 32'd1, 32'd0, 1, 32'h0100_0000, ST_OK},
			'{OP_MASH, 32'd5, 32'd2, 32'd3, 1, 32'd0, ST_NO_DEN},
			'{OP_MASH, 32'd3, 32'd2, 32'd3, 1, 32'd0, ST_OK},
			'{OP_MASH, 32'd1000, 32'd50000, 32'd70000, 0, 32'd0, ST_OK},
			'{OP_MASH, 32'd1, '1, '1, 0, 32'd0, ST_OK},
			'{OP_SPARE_A, 32'd1, 32'd2, 32'd3, 1, 32'd0, ST_NO_DEN},
			'{OP_SPARE_B, '1, '1, '1, 1, 32'd0, ST_NO_DEN},
			'{OP_SPARE_C, 32'd0, 32'd0, 32'd0, 1, 32'd0, ST_NO_DEN}
		};
		k_plan = '{6'd1, 6'd32, 6'd63, 6'd0, KMER_RESET, 6'($urandom_range(2, 62))};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_cells[i])
			send_cell(directed_cells[i], $urandom_range(0, 4));
		foreach (k_plan[p]) begin
			drain_pipe();
			write_klen(k_plan[p]);
			steady = 0;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (i % 40 == 0)
					steady = $urandom_range(0, 1);
				send_cell(draw_cell(), steady ? 0 : $urandom_range(0, 4));
			end
		end
		drain_pipe();
		$display("tb: %0d result words checked over %0d k-mer length settings", checked, settings);
		$display("tb: all five metrics, spare opcodes and zero-denominator cases driven");
		if (mismatches == 0 && pending_metrics.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
